@@ src/scps_pkg.sv @@
// ----------------------------------------------------------------------------
// scps_pkg
// Shared types and constants for the serial clock prescaler search block.
// ----------------------------------------------------------------------------
package scps_pkg;

    localparam int DATA_W   = 32;
    localparam int FACTOR_W = 4;
    localparam int EXP_W    = 3;
    localparam int FIELD_W  = 8;
    localparam int BCNT_W   = $clog2(DATA_W);

    // input beat
    typedef struct packed {
        logic [DATA_W-1:0] core_clock_hz;
        logic [DATA_W-1:0] wanted_max_hz;
    } in_t;

    // result beat
    typedef struct packed {
        logic [FACTOR_W-1:0] factor;
        logic [EXP_W-1:0]    exponent;
        logic [FIELD_W-1:0]  packed_field;
        logic                exact_hit;
        logic                failed;
    } out_t;

    // controller to datapath commands
    typedef struct packed {
        logic start;
        logic div_step;
        logic eval;
        logic next_factor;
        logic out_load;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_last;
        logic exp_last;
        logic factor_last;
        logic hit;
    } sts_t;

endpackage

@@ src/scps_ctrl.sv @@
// ----------------------------------------------------------------------------
// scps_ctrl
// Sequencer for the prescaler search: divide, scan exponents, emit result.
// ----------------------------------------------------------------------------
module scps_ctrl import scps_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    output cmd_t cmd,
    input  sts_t sts
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    // next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
                if (sts.hit) begin
                    state_next = ST_DONE;
                end else if (sts.exp_last) begin
                    if (sts.factor_last) begin
                        state_next = ST_DONE;
                    end else begin
                        cmd.next_factor = 1'b1;
                        state_next      = ST_DIV;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output valid: set on load, cleared when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ src/scps_dp.sv @@
// ----------------------------------------------------------------------------
// scps_dp
// Bit-serial divider by the linear factor, exponent shift compare and
// best-pair tracking, plus the result register.
// ----------------------------------------------------------------------------
module scps_dp import scps_pkg::*; #(
    parameter int MAX_FACTOR   = 15,
    parameter int MAX_EXPONENT = 7
) (
    input  logic aclk,
    input  in_t  s_data,
    input  cmd_t cmd,
    output sts_t sts,
    output out_t m_data
);

    localparam logic [FACTOR_W-1:0] FACTOR_END = MAX_FACTOR[FACTOR_W-1:0];
    localparam logic [EXP_W-1:0]    EXP_END    = MAX_EXPONENT[EXP_W-1:0];
    localparam logic [BCNT_W-1:0]   BCNT_END   = BCNT_W'(DATA_W - 1);

    logic [DATA_W-1:0]   core_reg, core_next;
    logic [DATA_W-1:0]   maxf_reg, maxf_next;
    logic [DATA_W-1:0]   quot_reg, quot_next;
    logic [FACTOR_W-1:0] rem_reg, rem_next;
    logic [BCNT_W-1:0]   bcnt_reg, bcnt_next;
    logic [FACTOR_W-1:0] f_reg, f_next;
    logic [EXP_W-1:0]    e_reg, e_next;
    logic [FACTOR_W-1:0] best_f_reg, best_f_next;
    logic [EXP_W-1:0]    best_e_reg, best_e_next;
    logic [DATA_W-1:0]   best_gap_reg, best_gap_next;
    logic                have_reg, have_next;
    logic                exact_reg, exact_next;
    out_t                out_reg, out_next;

    logic [FACTOR_W:0]   rem_wide;
    logic [FACTOR_W:0]   rem_diff;
    logic                rem_ge;
    logic [DATA_W-1:0]   clk_div;
    logic [DATA_W-1:0]   gap;
    logic                fits;

    // one restoring division step
    assign rem_wide = {rem_reg, quot_reg[DATA_W-1]};
    assign rem_ge   = (rem_wide >= {1'b0, f_reg});
    assign rem_diff = rem_wide - {1'b0, f_reg};

    // divided clock of the current pair and its shortfall
    assign clk_div = quot_reg >> e_reg;
    assign fits    = (clk_div <= maxf_reg);
    assign gap     = maxf_reg - clk_div;

    assign sts.div_last    = (bcnt_reg == BCNT_END);
    assign sts.exp_last    = (e_reg == EXP_END);
    assign sts.factor_last = (f_reg == FACTOR_END);
    assign sts.hit         = (clk_div == maxf_reg);

    always_comb begin
        core_next     = core_reg;
        maxf_next     = maxf_reg;
        quot_next     = quot_reg;
        rem_next      = rem_reg;
        bcnt_next     = bcnt_reg;
        f_next        = f_reg;
        e_next        = e_reg;
        best_f_next   = best_f_reg;
        best_e_next   = best_e_reg;
        best_gap_next = best_gap_reg;
        have_next     = have_reg;
        exact_next    = exact_reg;
        out_next      = out_reg;

        // new search
        if (cmd.start) begin
            core_next  = s_data.core_clock_hz;
            maxf_next  = s_data.wanted_max_hz;
            quot_next  = s_data.core_clock_hz;
            rem_next   = '0;
            bcnt_next  = '0;
            f_next     = FACTOR_W'(1);
            e_next     = '0;
            have_next  = 1'b0;
            exact_next = 1'b0;
        end

        // divider iteration
        if (cmd.div_step) begin
            rem_next  = rem_ge ? rem_diff[FACTOR_W-1:0] : rem_wide[FACTOR_W-1:0];
            quot_next = {quot_reg[DATA_W-2:0], rem_ge};
            bcnt_next = bcnt_reg + BCNT_W'(1);
        end

        // evaluate one exponent against the best so far
        if (cmd.eval) begin
            e_next = e_reg + EXP_W'(1);
            if (fits) begin
                if (sts.hit) begin
                    best_f_next = f_reg;
                    best_e_next = e_reg;
                    have_next   = 1'b1;
                    exact_next  = 1'b1;
                end else if (!have_reg || (gap < best_gap_reg)) begin
                    best_f_next   = f_reg;
                    best_e_next   = e_reg;
                    best_gap_next = gap;
                    have_next     = 1'b1;
                end
            end
        end

        // restart division for the next factor
        if (cmd.next_factor) begin
            f_next    = f_reg + FACTOR_W'(1);
            e_next    = '0;
            quot_next = core_reg;
            rem_next  = '0;
            bcnt_next = '0;
        end

        // result register
        if (cmd.out_load) begin
            if (have_reg) begin
                out_next.factor       = best_f_reg;
                out_next.exponent     = best_e_reg;
                out_next.packed_field = {best_e_reg[2:1], 1'b0, best_e_reg[0], best_f_reg};
                out_next.exact_hit    = exact_reg;
                out_next.failed       = 1'b0;
            end else begin
                out_next        = '0;
                out_next.failed = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        core_reg     <= core_next;
        maxf_reg     <= maxf_next;
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        bcnt_reg     <= bcnt_next;
        f_reg        <= f_next;
        e_reg        <= e_next;
        best_f_reg   <= best_f_next;
        best_e_reg   <= best_e_next;
        best_gap_reg <= best_gap_next;
        have_reg     <= have_next;
        exact_reg    <= exact_next;
        out_reg      <= out_next;
    end

    assign m_data = out_reg;

endmodule

@@ src/spi_clock_prescaler_search_core.sv @@
// ----------------------------------------------------------------------------
// spi_clock_prescaler_search_core
// Finds the serial clock prescale pair closest to, and not above, a maximum.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one beat holding the core clock and the highest
//   allowed serial clock. The m_ channel returns one beat with the chosen
//   factor, exponent, packed prescale field, exact-hit and failed flags.
//   Factors 1..MAX_FACTOR are tried in turn; each costs a bit-serial
//   division by the factor followed by an evaluation of each exponent
//   0..MAX_EXPONENT, where the quotient is shifted and compared.
//   After the search the result is loaded into the output register; an
//   exact match ends the search early. Most of the search time is spent in
//   the divider loop. One beat is worked on at a time; s_ready is high only
//   while idle, so a new beat is taken only after the full search, the
//   result load and a return to idle.
//   The result sits in an output register; if the receiver stalls, the
//   next beat may be accepted, but its result waits until the slot frees.
//   Reset (aresetn low, synchronous) returns to idle with m_valid low.
// ----------------------------------------------------------------------------
module spi_clock_prescaler_search_core import scps_pkg::*; #(
    parameter int MAX_FACTOR   = 15,
    parameter int MAX_EXPONENT = 7
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    cmd_t cmd;
    sts_t sts;

    // sequencer
    scps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // divider, compare and result datapath
    scps_dp #(
        .MAX_FACTOR   (MAX_FACTOR),
        .MAX_EXPONENT (MAX_EXPONENT)
    ) u_dp (
        .aclk   (aclk),
        .s_data (s_data),
        .cmd    (cmd),
        .sts    (sts),
        .m_data (m_data)
    );

endmodule
